/* rtl/bsc_pkg.sv */
package bsc_pkg;

  localparam int LANES     = 8;
  localparam int ELEM_BITS = 64;

  localparam int LCNT_W  = 4;
  localparam int OCNT_W  = 4;
  localparam int TOTAL_W = 40;

  localparam int PCNT_W = $clog2(LANES);
  localparam int CNT_W  = $clog2(LANES + 1);
  localparam int POS_W  = $clog2(2 * LANES);

  localparam int IN_RAW_W   = LANES * ELEM_BITS + LCNT_W;
  localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = LANES * ELEM_BITS + OCNT_W + TOTAL_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef logic [LANES-1:0][ELEM_BITS-1:0] elems_t;

  typedef struct packed {
    elems_t              elems;
    logic [OCNT_W-1:0]   count;
    logic [TOTAL_W-1:0]  total;
    logic                fin;
  } res_t;

endpackage

/* rtl/bitmap_stream_compaction.sv */
// Bitmap stream compaction. Each input item carries a group of LANES elements
// (s_tdata), a keep mask (s_tuser) and a lane count; s_tlast marks the last
// group of a column. Kept lanes are packed densely in lane order and leave as
// full words of LANES elements; on the last group the remainder leaves as a
// partial (possibly empty) word with m_tlast set. Every word carries the
// column's running kept total (including the whole current group, saturating
// at 2^40-1); lanes at or beyond out_count are zero. One item is taken per
// cycle: an input register feeds single-pass packing logic that writes a
// three-entry result queue, so an item passes through the input register and
// the queue before its first result, and the rate is one item per cycle as
// long as results are drained at one per cycle (a last group that also fills
// a word yields two results and holds the next item until a result drains).
module bitmap_stream_compaction
  import bsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // lane_0 .. lane_(LANES-1), lane_count, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // keep_mask
  input  logic [LANES-1:0]      s_tuser,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // out_0 .. out_(LANES-1), out_count, total_kept, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  // input register
  logic              in_v;
  elems_t            in_lanes;
  logic [LANES-1:0]  in_mask;
  logic [LCNT_W-1:0] in_cnt;
  logic              in_last;

  // column state
  elems_t             pend;
  elems_t             pend_next;
  logic [PCNT_W-1:0]  pcnt;
  logic [PCNT_W-1:0]  pcnt_next;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] total_next;

  // result queue, head at entry 0
  res_t       q [3];
  res_t       q_next [3];
  logic [1:0] qcnt;
  logic [1:0] qcnt_next;

  logic advance;
  logic pop;
  logic have_full;
  res_t res_a;
  res_t res_b;
  logic [1:0] push_n;

  logic [LANES-1:0]          lmask;
  logic [LANES-1:0][CNT_W-1:0] rank;
  logic [CNT_W-1:0]          kcnt;
  logic [POS_W-1:0]          sum;
  logic [ELEM_BITS-1:0]      slot [2*LANES];
  logic [TOTAL_W:0]          tsum;
  logic [CNT_W-1:0]          rem_cnt;

  assign advance  = in_v && (qcnt <= 2'd1);
  assign s_tready = !in_v || advance;
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_lanes <= s_tdata[LANES*ELEM_BITS-1:0];
      in_mask  <= s_tuser;
      in_cnt   <= s_tdata[LANES*ELEM_BITS +: LCNT_W];
      in_last  <= s_tlast;
    end
  end

  // lane selection, ranks and slot placement
  always_comb begin
    int vcnt;
    vcnt = (int'(in_cnt) > LANES) ? LANES : int'(in_cnt);
    for (int i = 0; i < LANES; i++) begin
      lmask[i] = in_mask[i] && (i < vcnt);
    end
    kcnt = '0;
    for (int i = 0; i < LANES; i++) begin
      rank[i] = kcnt;
      kcnt    = kcnt + CNT_W'(lmask[i]);
    end
    sum       = POS_W'(pcnt) + POS_W'(kcnt);
    have_full = (int'(sum) >= LANES);
    for (int j = 0; j < 2 * LANES; j++) begin
      slot[j] = (j < LANES) ? pend[j % LANES] : '0;
      for (int i = 0; i < LANES; i++) begin
        if (lmask[i] && (POS_W'(pcnt) + POS_W'(rank[i]) == POS_W'(j))) begin
          slot[j] = in_lanes[i];
        end
      end
    end
    for (int j = 0; j < LANES; j++) begin
      pend_next[j] = have_full ? slot[j + LANES] : slot[j];
    end
    rem_cnt = have_full ? CNT_W'(sum - POS_W'(LANES)) : CNT_W'(sum);
    tsum    = {1'b0, total} + (TOTAL_W + 1)'(kcnt);
    total_next = tsum[TOTAL_W] ? TOTAL_MAX : tsum[TOTAL_W-1:0];
    pcnt_next  = in_last ? '0 : PCNT_W'(rem_cnt);
  end

  // result words
  always_comb begin
    res_t full_w;
    res_t fin_w;
    for (int j = 0; j < LANES; j++) begin
      full_w.elems[j] = slot[j];
      fin_w.elems[j]  = (j < int'(rem_cnt)) ? pend_next[j] : '0;
    end
    full_w.count = OCNT_W'(LANES);
    full_w.total = total_next;
    full_w.fin   = 1'b0;
    fin_w.count  = OCNT_W'(rem_cnt);
    fin_w.total  = total_next;
    fin_w.fin    = 1'b1;
    res_a  = have_full ? full_w : fin_w;
    res_b  = fin_w;
    push_n = advance ? (2'(have_full) + 2'(in_last)) : 2'd0;
  end

  // queue update: pop from the head, append behind the remaining entries
  always_comb begin
    logic [1:0] base;
    base = qcnt - 2'(pop);
    q_next[0] = pop ? q[1] : q[0];
    q_next[1] = pop ? q[2] : q[1];
    q_next[2] = q[2];
    for (int j = 0; j < 3; j++) begin
      if (push_n != 2'd0 && 2'(j) == base) begin
        q_next[j] = res_a;
      end
      if (push_n == 2'd2 && 2'(j) == base + 2'd1) begin
        q_next[j] = res_b;
      end
    end
    qcnt_next = base + push_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pcnt  <= '0;
      total <= '0;
      qcnt  <= '0;
    end else begin
      qcnt <= qcnt_next;
      if (advance) begin
        pcnt  <= pcnt_next;
        total <= in_last ? '0 : total_next;
      end
    end
    if (advance) begin
      pend <= pend_next;
    end
    for (int j = 0; j < 3; j++) begin
      q[j] <= q_next[j];
    end
  end

  assign m_tvalid = (qcnt != 2'd0);
  assign m_tdata  = OUT_DATA_W'({q[0].total, q[0].count, q[0].elems});
  assign m_tlast  = q[0].fin;

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> pcnt == '0 && total == '0)
    else $error("column state not cleared after last group");

  a_result_shows: assert property (@(posedge clk) disable iff (rst)
    advance && (have_full || in_last) |=> m_tvalid)
    else $error("result item missing after group");

  a_nonfinal_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !q[0].fin |-> q[0].count == OCNT_W'(LANES))
    else $error("non-final word is not full");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    push_n == 2'd2 |-> qcnt <= 2'd1)
    else $error("result queue overrun");

endmodule

/* test/bsc_checker.sv */
`timescale 1ns / 100ps

module bsc_checker
  import bsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  // lane_0 .. lane_(LANES-1), lane_count, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // keep_mask
  input  logic [LANES-1:0]      s_tuser,
  input  logic                  s_tlast,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // out_0 .. out_(LANES-1), out_count, total_kept, zero pad
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tlast,
  output int                    err_count,
  output int                    expected_left
);

  elems_t             pend_elems;
  int                 pend_cnt;
  logic [TOTAL_W-1:0] run_total;
  res_t               words_due[$];
  int                 errs;

  // appends the kept lanes of one group and queues the words it completes
  task automatic pack_group(input elems_t grp, input logic [LANES-1:0] keep,
                            input logic [LCNT_W-1:0] lcnt, input logic lst);
    int     n_valid;
    elems_t full_snap;
    bit     got_full;
    res_t   w;
    n_valid = (lcnt > LANES) ? LANES : int'(lcnt);
    got_full = 1'b0;
    full_snap = '0;
    for (int i = 0; i < n_valid; i++) begin
      if (keep[i]) begin
        pend_elems[pend_cnt] = grp[i];
        pend_cnt++;
        if (run_total != TOTAL_MAX) run_total++;
        if (pend_cnt == LANES) begin
          full_snap = pend_elems;
          got_full = 1'b1;
          pend_cnt = 0;
        end
      end
    end
    // total on a full word already covers the whole group
    if (got_full) begin
      w.elems = full_snap;
      w.count = OCNT_W'(LANES);
      w.total = run_total;
      w.fin   = 1'b0;
      words_due.push_back(w);
    end
    if (lst) begin
      w.elems = '0;
      for (int j = 0; j < pend_cnt; j++) w.elems[j] = pend_elems[j];
      w.count = OCNT_W'(pend_cnt);
      w.total = run_total;
      w.fin   = 1'b1;
      words_due.push_back(w);
      pend_cnt = 0;
      run_total = '0;
    end
  endtask

  task automatic check_word(input res_t got);
    res_t want;
    if (words_due.size() == 0) begin
      $error("output word with no expectation waiting");
      errs++;
    end else begin
      want = words_due.pop_front();
      for (int j = 0; j < LANES; j++) begin
        if (got.elems[j] !== want.elems[j]) begin
          $error("out_%0d: expected %h, got %h", j, want.elems[j], got.elems[j]);
          errs++;
        end
      end
      if (got.count !== want.count) begin
        $error("out_count: expected %0d, got %0d", want.count, got.count);
        errs++;
      end
      if (got.total !== want.total) begin
        $error("total_kept: expected %0d, got %0d", want.total, got.total);
        errs++;
      end
      if (got.fin !== want.fin) begin
        $error("final_word: expected %0b, got %0b", want.fin, got.fin);
        errs++;
      end
    end
  endtask

  initial begin
    errs = 0;
    err_count = 0;
    expected_left = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      pend_elems = '0;
      pend_cnt = 0;
      run_total = '0;
      words_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        check_word('{elems: m_tdata[LANES*ELEM_BITS-1:0],
                     count: m_tdata[LANES*ELEM_BITS +: OCNT_W],
                     total: m_tdata[LANES*ELEM_BITS+OCNT_W +: TOTAL_W],
                     fin:   m_tlast});
      end
      if (s_tvalid && s_tready) begin
        pack_group(s_tdata[LANES*ELEM_BITS-1:0], s_tuser,
                   s_tdata[LANES*ELEM_BITS +: LCNT_W], s_tlast);
      end
    end
    err_count <= errs;
    expected_left <= words_due.size();
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import bsc_pkg::*;

  localparam int NUM_ITEMS   = 1400;
  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 400;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [LANES-1:0]      s_tuser;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  int                    err_count;
  int                    expected_left;
  int                    cycle_cnt = 0;
  int                    burst_left;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bitmap_stream_compaction u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  bsc_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .err_count     (err_count),
    .expected_left (expected_left)
  );

  function automatic elems_t rand_elems();
    elems_t e;
    for (int i = 0; i < LANES; i++) e[i] = {$urandom, $urandom};
    return e;
  endfunction

  // offers one group and returns at the edge where it is taken
  task automatic push_group(input elems_t grp, input logic [LANES-1:0] keep,
                            input logic [LCNT_W-1:0] lcnt, input logic lst);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'({lcnt, grp});
    s_tuser  <= keep;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  // receiver: segments of varying ready density, with a long hold-off now and then
  initial begin
    int seg;
    int mode;
    m_tready = 1'b0;
    seg = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (seg % 30 == 3) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 200)) begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
      seg++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("** bitmap_stream_compaction: FAILED **");
      $finish;
    end
  end

  initial begin
    int               n_sent;
    int               col_len;
    int               pick;
    logic [LCNT_W-1:0] lcnt;
    logic [LANES-1:0]  keep;
    elems_t           grp;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    s_tlast = 1'b0;
    burst_left = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed groups
    push_group('1, 8'hff, 4'd8, 1'b0);            // all ones, exact full word
    push_group('0, 8'h00, 4'd8, 1'b1);            // nothing left: empty final word
    push_group('1, 8'hff, 4'd8, 1'b1);            // full word on a last group
    push_group(rand_elems(), 8'hff, 4'd0, 1'b1);  // zero lanes valid
    push_group(rand_elems(), 8'hff, 4'd15, 1'b0); // count above lanes saturates
    push_group(rand_elems(), 8'h0f, 4'd12, 1'b0);
    push_group(rand_elems(), 8'hff, 4'd3, 1'b0);  // short group mid-column
    push_group(rand_elems(), 8'haa, 4'd5, 1'b0);
    push_group(rand_elems(), 8'h01, 4'd1, 1'b1);
    push_group(rand_elems(), 8'h80, 4'd8, 1'b0);
    push_group(rand_elems(), 8'h81, 4'd7, 1'b0);  // lane 7 outside the count
    push_group(rand_elems(), 8'h55, 4'd8, 1'b0);
    push_group(rand_elems(), 8'hfe, 4'd9, 1'b0);
    push_group(rand_elems(), 8'h7f, 4'd8, 1'b1);
    push_group(rand_elems(), 8'h00, 4'd0, 1'b0);
    push_group(rand_elems(), 8'h00, 4'd0, 1'b1);
    push_group(rand_elems(), 8'h3c, 4'd4, 1'b1);
    push_group({LANES{64'haaaa_aaaa_aaaa_aaaa}}, 8'h55, 4'd8, 1'b0);
    push_group({LANES{64'h5555_5555_5555_5555}}, 8'haa, 4'd8, 1'b1);

    // random columns, mostly well formed with full groups and a short tail
    n_sent = 0;
    while (n_sent < NUM_ITEMS) begin
      col_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                            : $urandom_range(1, 12);
      for (int g = 0; g < col_len; g++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) lcnt = LCNT_W'($urandom_range(0, 15));
        else if (g == col_len - 1)
          lcnt = ($urandom_range(0, 3) == 0) ? LCNT_W'(8)
                                             : LCNT_W'($urandom_range(1, 8));
        else lcnt = LCNT_W'(8);
        case ($urandom_range(0, 5))
          0: keep = 8'hff;
          1: keep = 8'h00;
          2: keep = 8'h01 << $urandom_range(0, 7);
          default: keep = 8'($urandom);
        endcase
        if ($urandom_range(0, 15) == 0) grp = $urandom_range(0, 1) ? '1 : '0;
        else grp = rand_elems();
        push_group(grp, keep, lcnt, g == col_len - 1);
        n_sent++;
      end
    end
    s_tvalid <= 1'b0;

    repeat (2) @(posedge clk);
    for (int k = 0; k < 5000 && expected_left != 0; k++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_left != 0) $error("%0d expected words never arrived", expected_left);
    if (err_count == 0 && expected_left == 0) begin
      $display("** bitmap_stream_compaction: PASSED **");
    end else begin
      $display("** bitmap_stream_compaction: FAILED **");
    end
    $finish;
  end

endmodule
